// File: src/abm_pkg.sv
// Shared types, constants and helper functions for the audio burst muter.
// Used by every module of the block; depends on nothing.
package abm_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int BLOCK_LEN   = 256;
	localparam int BLK_BITS    = 8;
	localparam int NBR_BLOCKS  = 16;
	localparam int RAMP_LEN    = 32;
	localparam int FADE_BITS   = 5;
	localparam int MIN_BLOCKS  = 4;
	localparam int RING_LEN    = 2 * NBR_BLOCKS + 1;
	localparam int RING_IW     = 6;
	localparam int MARK_DEPTH  = 32;
	localparam int MARK_IW     = 5;
	localparam int ENERGY_W    = 56;
	localparam int CNT_W       = 40;
	localparam int BLK_W       = CNT_W - BLK_BITS;
	localparam int WIN_W       = 6;
	localparam int LEVEL_W     = 23;
	localparam int RATIO_W     = 4;

	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST   = 23'd41943;
	localparam logic [RATIO_W-1:0] BURST_RATIO_RST = 4'd5;

	typedef enum logic {
		REG_MIN_LEVEL   = 1'b0,
		REG_BURST_RATIO = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DRAIN_CHK,
		ST_D_INIT,
		ST_D_CAND,
		ST_D_CLOAD,
		ST_D_SCAN,
		ST_D_TEST,
		ST_D_EREAD,
		ST_D_DECIDE,
		ST_READ,
		ST_FADE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic push;
		logic drain_start;
		logic dec_init;
		logic cand_rd;
		logic cand_load;
		logic scan;
		logic next_cand;
		logic eread;
		logic decide;
		logic read;
		logic fade;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic draining;
		logic seen_zero;
		logic need_decide;
		logic can_emit;
		logic more_decide;
		logic scan_last;
		logic found;
		logic out_free;
	} stat_t;

	function automatic logic [RING_IW-1:0] ring_inc(input logic [RING_IW-1:0] idx);
		logic [RING_IW-1:0] nxt;
		nxt = (idx == RING_IW'(RING_LEN - 1)) ? '0 : idx + 1'b1;
		return nxt;
	endfunction

	// Scale by f/RAMP_LEN, truncating toward zero
	function automatic logic signed [SAMPLE_BITS-1:0] fade_scale(
		input logic signed [SAMPLE_BITS-1:0] s,
		input logic [BLK_BITS:0] f
	);
		logic signed [SAMPLE_BITS+BLK_BITS+1:0] prod;
		logic signed [SAMPLE_BITS+BLK_BITS+1:0] adj;
		prod = s * $signed({1'b0, f});
		adj  = (prod < 0) ? prod + (SAMPLE_BITS+BLK_BITS+2)'(RAMP_LEN - 1) : prod;
		return SAMPLE_BITS'(adj >>> FADE_BITS);
	endfunction

endpackage

// File: src/abm_if.sv
// Valid/ready channel interfaces for the audio burst muter.
// Depends on abm_pkg for the sample width.
interface abm_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   mode;
	logic signed [abm_pkg::SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output mode, output sample_in, input ready);
	modport sink (input valid, input mode, input sample_in, output ready);
endinterface

interface abm_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [abm_pkg::SAMPLE_BITS-1:0] sample_out;
	logic                                   in_burst;
	logic                                   last;

	modport source (output valid, output sample_out, output in_burst, output last, input ready);
	modport sink (input valid, input sample_out, input in_burst, input last, output ready);
endinterface

// File: src/abm_regs.sv
// APB-style configuration registers: min_level and burst_ratio.
// Depends on abm_pkg.
module abm_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output logic [abm_pkg::LEVEL_W-1:0]         min_level,
	output logic [abm_pkg::RATIO_W-1:0]         burst_ratio
);

	logic [abm_pkg::LEVEL_W-1:0] min_level_q;
	logic [abm_pkg::RATIO_W-1:0] burst_ratio_q;
	abm_pkg::reg_idx_t           idx;
	logic                        wr_en;

	assign idx    = abm_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q   <= abm_pkg::MIN_LEVEL_RST;
			burst_ratio_q <= abm_pkg::BURST_RATIO_RST;
		end else if (wr_en) begin
			case (idx)
				abm_pkg::REG_MIN_LEVEL:   min_level_q   <= pwdata[abm_pkg::LEVEL_W-1:0];
				abm_pkg::REG_BURST_RATIO: burst_ratio_q <= pwdata[abm_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			abm_pkg::REG_MIN_LEVEL:   prdata = {{(32-abm_pkg::LEVEL_W){1'b0}}, min_level_q};
			abm_pkg::REG_BURST_RATIO: prdata = {{(32-abm_pkg::RATIO_W){1'b0}}, burst_ratio_q};
			default:                  prdata = '0;
		endcase
	end

	assign min_level   = min_level_q;
	assign burst_ratio = burst_ratio_q;

endmodule

// File: src/abm_ctrl.sv
// Controller state machine: sequences push, block decision, drain and emit.
// Depends on abm_pkg; drives the datapath through cmd_t, reads stat_t.
module abm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_mode,
	output logic            in_ready,
	input  abm_pkg::stat_t  stat,
	output abm_pkg::cmd_t   cmd
);

	abm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			abm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_mode) begin
						// drop pushes once draining has begun
						if (!stat.draining) begin
							cmd.push = 1'b1;
							state_d  = abm_pkg::ST_CHECK;
						end
					end else if (!stat.seen_zero) begin
						if (!stat.draining) begin
							cmd.drain_start = 1'b1;
							state_d         = abm_pkg::ST_DRAIN_CHK;
						end else begin
							state_d = abm_pkg::ST_READ;
						end
					end
				end
			end
			abm_pkg::ST_CHECK: begin
				if (stat.need_decide) begin
					state_d = abm_pkg::ST_D_INIT;
				end else if (stat.can_emit) begin
					state_d = abm_pkg::ST_READ;
				end else begin
					state_d = abm_pkg::ST_IDLE;
				end
			end
			abm_pkg::ST_DRAIN_CHK: begin
				state_d = stat.more_decide ? abm_pkg::ST_D_INIT : abm_pkg::ST_READ;
			end
			abm_pkg::ST_D_INIT: begin
				cmd.dec_init = 1'b1;
				state_d      = abm_pkg::ST_D_CAND;
			end
			abm_pkg::ST_D_CAND: begin
				cmd.cand_rd = 1'b1;
				state_d     = abm_pkg::ST_D_CLOAD;
			end
			abm_pkg::ST_D_CLOAD: begin
				cmd.cand_load = 1'b1;
				state_d       = abm_pkg::ST_D_SCAN;
			end
			abm_pkg::ST_D_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = abm_pkg::ST_D_TEST;
				end
			end
			abm_pkg::ST_D_TEST: begin
				if (stat.found) begin
					state_d = abm_pkg::ST_D_EREAD;
				end else begin
					cmd.next_cand = 1'b1;
					state_d       = abm_pkg::ST_D_CAND;
				end
			end
			abm_pkg::ST_D_EREAD: begin
				cmd.eread = 1'b1;
				state_d   = abm_pkg::ST_D_DECIDE;
			end
			abm_pkg::ST_D_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.draining ? abm_pkg::ST_DRAIN_CHK : abm_pkg::ST_CHECK;
			end
			abm_pkg::ST_READ: begin
				cmd.read = 1'b1;
				state_d  = abm_pkg::ST_FADE;
			end
			abm_pkg::ST_FADE: begin
				cmd.fade = 1'b1;
				state_d  = abm_pkg::ST_EMIT;
			end
			abm_pkg::ST_EMIT: begin
				// hold until the output register can take the item
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = abm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = abm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/abm_dp.sv
// Datapath: sample store, block energy ring, median selection, burst marks,
// fades and the output register. Depends on abm_pkg; steered by abm_ctrl.
module abm_dp #(
	parameter int STORE_DEPTH = 8192
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  abm_pkg::cmd_t                          cmd,
	output abm_pkg::stat_t                         stat,
	input  logic signed [abm_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic [abm_pkg::LEVEL_W-1:0]            min_level,
	input  logic [abm_pkg::RATIO_W-1:0]            burst_ratio,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic signed [abm_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                   in_burst,
	output logic                                   last
);

	localparam int SAW = $clog2(STORE_DEPTH);
	localparam int SW  = abm_pkg::SAMPLE_BITS;
	localparam int EW  = abm_pkg::ENERGY_W;
	localparam int CW  = abm_pkg::CNT_W;
	localparam int BW  = abm_pkg::BLK_W;
	localparam int LB  = abm_pkg::BLK_BITS;
	localparam int RW  = abm_pkg::RING_IW;
	localparam int NW  = abm_pkg::WIN_W;
	localparam int MW  = abm_pkg::MARK_IW;
	localparam int LW  = abm_pkg::LEVEL_W;

	// memories
	logic signed [SW-1:0] store_mem [STORE_DEPTH];
	logic [EW-1:0]        ring_mem [abm_pkg::RING_LEN];
	logic signed [SW-1:0] store_rd_q;
	logic [EW-1:0]        ring_rd_q;
	logic [RW-1:0]        ring_raddr;

	// stream control state
	logic [CW-1:0]                 seen_q, emitted_q;
	logic [BW-1:0]                 decided_q;
	logic [RW-1:0]                 dec_idx_q, wr_idx_q;
	logic [EW-1:0]                 acc_q;
	logic                          draining_q;
	logic [abm_pkg::MARK_DEPTH-1:0] marks_q;
	logic [SAW-1:0]                st_wr_q, st_rd_q;
	logic                          out_valid_q;

	// decision working registers
	logic [RW-1:0]      ws_idx_q, cand_ptr_q, scan_ptr_q;
	logic [NW-1:0]      n_q, j_q, lt_q, le_q;
	logic [EW-1:0]      cand_q;
	logic [7:0]         r2_q;
	logic [2*LW-1:0]    thr_q;
	logic [EW+7:0]      prod_q;

	// emit working registers
	logic               cur_q, prev_q, next_q, last_q;
	logic [LB-1:0]      pos_q;
	logic signed [SW-1:0] s1_q;
	logic signed [SW-1:0] out_sample_q;
	logic               out_burst_q, out_last_q;

	logic [BW-1:0]      nbc, ws_blk, cb, cb_prev, cb_next;
	logic signed [2*SW-1:0] sq_s;
	logic [EW:0]        acc_sum;
	logic [EW-1:0]      acc_sat;
	logic               blk_done, last_now, clear;
	logic [CW:0]        need_sum;
	logic [RW-1:0]      ws_idx_d;
	logic [NW-1:0]      k_half;
	logic               burst;
	logic [EW-1:0]      thr_full;
	logic signed [SW-1:0] s2;
	logic [LB:0]        down_f;

	assign nbc      = seen_q[CW-1:LB];
	assign blk_done = (seen_q[LB-1:0] == '1);
	assign sq_s     = sample_in * sample_in;
	assign acc_sum  = {1'b0, acc_q} + {{(EW+1-2*SW){1'b0}}, $unsigned(sq_s)};
	assign acc_sat  = acc_sum[EW] ? '1 : acc_sum[EW-1:0];
	assign need_sum = {1'b0, emitted_q} + (CW+1)'(abm_pkg::RAMP_LEN);
	assign k_half   = n_q >> 1;
	assign last_now = draining_q && ((emitted_q + 1'b1) >= seen_q);
	assign clear    = cmd.emit && last_q;
	assign ws_blk   = (decided_q >= BW'(abm_pkg::NBR_BLOCKS))
	                  ? decided_q - BW'(abm_pkg::NBR_BLOCKS) : '0;

	always_comb begin
		if (decided_q < BW'(abm_pkg::NBR_BLOCKS)) begin
			ws_idx_d = '0;
		end else if (dec_idx_q >= RW'(abm_pkg::NBR_BLOCKS)) begin
			ws_idx_d = dec_idx_q - RW'(abm_pkg::NBR_BLOCKS);
		end else begin
			ws_idx_d = dec_idx_q + RW'(abm_pkg::RING_LEN - abm_pkg::NBR_BLOCKS);
		end
	end

	always_comb begin
		ring_raddr = ws_idx_q;
		if (cmd.cand_rd) begin
			ring_raddr = cand_ptr_q;
		end else if (cmd.scan) begin
			ring_raddr = scan_ptr_q;
		end else if (cmd.eread) begin
			ring_raddr = dec_idx_q;
		end
	end

	// status
	always_comb begin
		stat.draining    = draining_q;
		stat.seen_zero   = (seen_q == '0);
		stat.need_decide = !draining_q &&
		                   ({1'b0, nbc} > ({1'b0, decided_q} + (BW+1)'(abm_pkg::NBR_BLOCKS)));
		stat.can_emit    = (emitted_q < seen_q) && (nbc >= BW'(abm_pkg::MIN_BLOCKS)) &&
		                   ({1'b0, decided_q} > need_sum[CW:LB]);
		stat.more_decide = decided_q < nbc;
		stat.scan_last   = (j_q == n_q - 1'b1);
		stat.found       = (lt_q <= k_half) && (k_half < le_q);
		stat.out_free    = !out_valid_q || out_ready;
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			store_mem[st_wr_q] <= sample_in;
		end
		if (cmd.read) begin
			store_rd_q <= store_mem[st_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && blk_done) begin
			ring_mem[wr_idx_q] <= acc_sat;
		end
		ring_rd_q <= ring_mem[ring_raddr];
	end

	// stream control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			emitted_q  <= '0;
			decided_q  <= '0;
			dec_idx_q  <= '0;
			wr_idx_q   <= '0;
			acc_q      <= '0;
			draining_q <= 1'b0;
			marks_q    <= '0;
			st_wr_q    <= '0;
			st_rd_q    <= '0;
		end else if (clear) begin
			seen_q     <= '0;
			emitted_q  <= '0;
			decided_q  <= '0;
			dec_idx_q  <= '0;
			wr_idx_q   <= '0;
			acc_q      <= '0;
			draining_q <= 1'b0;
			marks_q    <= '0;
			st_wr_q    <= '0;
			st_rd_q    <= '0;
		end else begin
			if (cmd.push) begin
				seen_q  <= seen_q + 1'b1;
				st_wr_q <= (st_wr_q == SAW'(STORE_DEPTH - 1)) ? '0 : st_wr_q + 1'b1;
				if (blk_done) begin
					acc_q    <= '0;
					wr_idx_q <= abm_pkg::ring_inc(wr_idx_q);
				end else begin
					acc_q <= acc_sat;
				end
			end
			if (cmd.drain_start) begin
				draining_q <= 1'b1;
				// short stream: nothing is a burst
				if (nbc < BW'(abm_pkg::MIN_BLOCKS)) begin
					decided_q <= nbc;
				end
			end
			if (cmd.decide) begin
				marks_q[decided_q[MW-1:0]] <= burst;
				decided_q                  <= decided_q + 1'b1;
				dec_idx_q                  <= abm_pkg::ring_inc(dec_idx_q);
			end
			if (cmd.emit) begin
				emitted_q <= emitted_q + 1'b1;
				st_rd_q   <= (st_rd_q == SAW'(STORE_DEPTH - 1)) ? '0 : st_rd_q + 1'b1;
			end
		end
	end

	// median search: count entries below and not above each candidate
	always_ff @(posedge clk) begin
		if (cmd.dec_init) begin
			ws_idx_q   <= ws_idx_d;
			cand_ptr_q <= ws_idx_d;
			n_q        <= NW'(nbc - ws_blk);
			r2_q       <= burst_ratio * burst_ratio;
			thr_q      <= min_level * min_level;
		end
		if (cmd.cand_load) begin
			cand_q     <= ring_rd_q;
			scan_ptr_q <= abm_pkg::ring_inc(ws_idx_q);
			j_q        <= '0;
			lt_q       <= '0;
			le_q       <= '0;
		end
		if (cmd.scan) begin
			scan_ptr_q <= abm_pkg::ring_inc(scan_ptr_q);
			j_q        <= j_q + 1'b1;
			lt_q       <= lt_q + NW'(ring_rd_q < cand_q);
			le_q       <= le_q + NW'(ring_rd_q <= cand_q);
		end
		if (cmd.next_cand) begin
			cand_ptr_q <= abm_pkg::ring_inc(cand_ptr_q);
		end
		if (cmd.eread) begin
			prod_q <= cand_q * r2_q;
		end
	end

	assign thr_full = {{(EW-2*LW-LB){1'b0}}, thr_q, {LB{1'b0}}};
	assign burst    = (ring_rd_q > thr_full) && (cand_q != '0) &&
	                  (prod_q < {8'b0, ring_rd_q});

	// emit path: neighbor marks, fade up, fade down, mute
	assign cb      = emitted_q[CW-1:LB];
	assign cb_prev = cb - 1'b1;
	assign cb_next = cb + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			pos_q  <= emitted_q[LB-1:0];
			cur_q  <= (cb < decided_q) && marks_q[cb[MW-1:0]];
			prev_q <= (cb != '0) && (cb_prev < decided_q) && marks_q[cb_prev[MW-1:0]] &&
			          (emitted_q[LB-1:0] < LB'(abm_pkg::RAMP_LEN));
			next_q <= ({1'b0, cb} + 1'b1 < {1'b0, decided_q}) && marks_q[cb_next[MW-1:0]] &&
			          (emitted_q[LB-1:0] >= LB'(abm_pkg::BLOCK_LEN - abm_pkg::RAMP_LEN));
			last_q <= last_now;
		end
		if (cmd.fade) begin
			s1_q <= prev_q ? abm_pkg::fade_scale(store_rd_q, {1'b0, pos_q}) : store_rd_q;
		end
	end

	assign down_f = (LB+1)'(abm_pkg::BLOCK_LEN) - {1'b0, pos_q};
	assign s2     = next_q ? abm_pkg::fade_scale(s1_q, down_f) : s1_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sample_q <= cur_q ? '0 : s2;
			out_burst_q  <= cur_q;
			out_last_q   <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_sample_q;
	assign in_burst   = out_burst_q;
	assign last       = out_last_q;

endmodule

// File: src/audio_burst_muter.sv
// Top level of the audio burst muter: registers, controller and datapath.
// Depends on abm_pkg, abm_if, abm_regs, abm_ctrl and abm_dp.
//
// Use: samples enter on din (mode 0 pushes sample_in, mode 1 is a drain tick
// after the stream ends) and leave delayed on dout with muted bursts and fades.
// Blocks are 256 samples; each is judged against the upper median energy of
// up to 33 neighboring blocks, so while pushing no sample leaves before 17
// blocks are in. Drain ticks then flush one sample each; last marks the final one.
// Per item: a push is checked and, when it releases a sample, that sample is read
// from the store, faded and registered on the output before the next item is
// taken. Once 17 blocks are in, the push that completes a block also decides one
// block: the median search over the energy ring compares one entry per cycle for
// each candidate in a window of n blocks. The first drain tick decides all open
// blocks (a stream under four has no bursts); later ones only read, fade, emit.
// Reset clears all stream state and loads the register defaults; the stores
// need no clearing. A stalled receiver holds the output register; the block
// keeps accepting items until the next result needs that register.
module audio_burst_muter #(
	parameter int STORE_DEPTH = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	abm_in_if.sink      din,
	abm_out_if.source   dout
);

	abm_pkg::cmd_t                 cmd;
	abm_pkg::stat_t                stat;
	logic [abm_pkg::LEVEL_W-1:0]   min_level;
	logic [abm_pkg::RATIO_W-1:0]   burst_ratio;

	abm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.min_level   (min_level),
		.burst_ratio (burst_ratio)
	);

	abm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_mode  (din.mode),
		.in_ready (din.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	abm_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.sample_in   (din.sample_in),
		.min_level   (min_level),
		.burst_ratio (burst_ratio),
		.out_ready   (dout.ready),
		.out_valid   (dout.valid),
		.sample_out  (dout.sample_out),
		.in_burst    (dout.in_burst),
		.last        (dout.last)
	);

endmodule

// File: src/abm_chk.sv
// Port-level checks for the audio burst muter, bound to the top level.
// Depends on abm_pkg for the sample width.
module abm_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [abm_pkg::SAMPLE_BITS-1:0] sample_out,
	input logic                                   in_burst,
	input logic                                   out_last,
	input logic                                   psel,
	input logic                                   penable,
	input logic                                   pready
);

	// a stalled item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) &&
		$stable(in_burst) && $stable(out_last))
		else $error("output item changed while stalled");

	// muted block samples are silent
	a_burst_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_burst |-> sample_out == '0)
		else $error("burst sample not muted");

	// configuration access never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("configuration access stalled");

endmodule

bind audio_burst_muter abm_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.sample_out (dout.sample_out),
	.in_burst   (dout.in_burst),
	.out_last   (dout.last),
	.psel       (psel),
	.penable    (penable),
	.pready     (pready)
);

// File: bench/abm_checker.sv
// Watches the sample channels and the register port of the burst muter,
// predicts every delayed sample and compares it. Depends on abm_pkg and abm_if.
`timescale 1ns / 1ps

module abm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	abm_in_if           din,
	abm_out_if          dout,
	output int          errors,
	output int          pending,
	output int          results,
	output int          bursts_seen
);

	localparam int DEPTH = 8192;
	localparam int SB    = abm_pkg::SAMPLE_BITS;
	localparam int BL    = abm_pkg::BLOCK_LEN;
	localparam int RL    = abm_pkg::RAMP_LEN;
	localparam int NB    = abm_pkg::NBR_BLOCKS;
	localparam int RN    = abm_pkg::RING_LEN;
	localparam int MD    = abm_pkg::MARK_DEPTH;

	typedef struct {
		logic signed [SB-1:0] smp;
		logic                 brst;
		logic                 lst;
	} sample_res_t;

	sample_res_t expected_samples[$];

	logic signed [SB-1:0]          store[DEPTH];
	longint unsigned               energy_ring[RN];
	bit                            marks[MD];
	longint unsigned               acc;
	longint unsigned               seen;
	longint unsigned               emitted;
	longint unsigned               decided;
	bit                            draining;
	logic [abm_pkg::LEVEL_W-1:0]   min_lvl;
	logic [abm_pkg::RATIO_W-1:0]   ratio;

	function automatic void clear_stream();
		foreach (marks[i]) marks[i] = 0;
		foreach (energy_ring[i]) energy_ring[i] = 0;
		acc      = 0;
		seen     = 0;
		emitted  = 0;
		decided  = 0;
		draining = 0;
	endfunction

	function automatic void judge_block(longint unsigned b, longint unsigned wend);
		longint unsigned win[$];
		longint unsigned ws, med, e, thr, r2;
		ws = (b >= NB) ? b - NB : 0;
		for (longint unsigned w = ws; w < wend && win.size() < RN; w++)
			win = {win, energy_ring[w % RN]};
		win.sort();
		med = (win.size() > 0) ? win[win.size() / 2] : 0;
		e   = energy_ring[b % RN];
		thr = longint'(min_lvl) * longint'(min_lvl) * BL;
		r2  = longint'(ratio) * longint'(ratio);
		marks[b % MD] = (e > thr) && (med > 0) && (r2 == 0 || med <= (e - 1) / r2);
	endfunction

	function automatic bit block_muted(longint unsigned b);
		return b < decided && marks[b % MD];
	endfunction

	// Mute and fade one pending sample; factors apply in block order
	function automatic void release_sample(longint unsigned p, bit fin);
		sample_res_t     r;
		longint          s;
		longint unsigned lo, hi, start, stop;
		s  = store[p % DEPTH];
		lo = (p >= RL) ? (p - RL) / BL : 0;
		hi = (p + RL) / BL;
		for (longint unsigned b = lo; b <= hi; b++) begin
			start = b * BL;
			stop  = start + BL;
			if (!block_muted(b))
				continue;
			if (p >= start && p < stop)
				s = 0;
			else if (p < start && p + RL >= start)
				s = s * longint'(start - p) / RL;
			else if (p >= stop && p < stop + RL)
				s = s * longint'(p - stop) / RL;
		end
		r.smp  = SB'(s);
		r.brst = block_muted(p / BL);
		r.lst  = fin;
		expected_samples = {expected_samples, r};
	endfunction

	function automatic void take_item(logic mode, logic signed [SB-1:0] smp);
		longint          sq;
		longint unsigned c, nbc, emax;
		bit              fin;
		emax = (64'd1 << abm_pkg::ENERGY_W) - 1;
		if (mode == 1'b0) begin
			if (draining)
				return;
			store[seen % DEPTH] = smp;
			seen++;
			sq = longint'(smp) * longint'(smp);
			if (longint'(sq) > emax - acc)
				acc = emax;
			else
				acc += sq;
			if (seen % BL == 0) begin
				c = seen / BL - 1;
				energy_ring[c % RN] = acc;
				acc = 0;
				if (c >= NB) begin
					judge_block(c - NB, c + 1);
					decided = c - NB + 1;
				end
			end
			nbc = seen / BL;
			if (emitted < seen && nbc >= abm_pkg::MIN_BLOCKS
					&& decided > (emitted + RL) / BL) begin
				release_sample(emitted, 1'b0);
				emitted++;
			end
			return;
		end
		if (seen == 0)
			return;
		if (!draining) begin
			draining = 1;
			nbc = seen / BL;
			if (nbc < abm_pkg::MIN_BLOCKS)
				foreach (marks[i]) marks[i] = 0;
			else
				for (longint unsigned b = decided; b < nbc; b++)
					judge_block(b, nbc);
			decided = nbc;
		end
		fin = (emitted + 1 >= seen);
		release_sample(emitted, fin);
		emitted++;
		if (fin)
			clear_stream();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_res_t exp_r;
		if (!arst_n) begin
			clear_stream();
			expected_samples.delete();
			min_lvl     <= abm_pkg::MIN_LEVEL_RST;
			ratio       <= abm_pkg::BURST_RATIO_RST;
			errors      <= 0;
			results     <= 0;
			bursts_seen <= 0;
			pending     <= 0;
		end else begin
			if (dout.valid && dout.ready) begin
				results <= results + 1;
				if (dout.in_burst)
					bursts_seen <= bursts_seen + 1;
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample %0d burst %0b last %0b", $time,
						dout.sample_out, dout.in_burst, dout.last);
					errors <= errors + 1;
				end else begin
					exp_r = expected_samples.pop_front();
					if (exp_r.smp !== dout.sample_out || exp_r.brst !== dout.in_burst
							|| exp_r.lst !== dout.last) begin
						$display("%0t: expected sample %0d burst %0b last %0b, got %0d %0b %0b",
							$time, exp_r.smp, exp_r.brst, exp_r.lst,
							dout.sample_out, dout.in_burst, dout.last);
						errors <= errors + 1;
					end
				end
			end
			if (din.valid && din.ready)
				take_item(din.mode, din.sample_in);
			if (psel && penable && pwrite && pready) begin
				if (abm_pkg::reg_idx_t'(paddr[2]) == abm_pkg::REG_MIN_LEVEL)
					min_lvl <= pwdata[abm_pkg::LEVEL_W-1:0];
				else
					ratio <= pwdata[abm_pkg::RATIO_W-1:0];
			end
			pending <= expected_samples.size();
		end
	end

endmodule

// File: bench/audio_burst_muter_tb.sv
// Top of the burst muter testbench: clock, reset, register writes and sample
// streams under several idle patterns. Depends on abm_pkg, abm_if, abm_checker.
`timescale 1ns / 1ps

module audio_burst_muter_tb;

	localparam int SB          = abm_pkg::SAMPLE_BITS;
	localparam int BL          = abm_pkg::BLOCK_LEN;
	localparam int MAIN_PUSHES = 4 * BL + 3;
	localparam int MAIN_DRAINS = 280;
	localparam int HOLD_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          results;
	int          bursts_seen;
	int          idle_pct;
	int          stall_pct;
	int          items_sent;
	bit          long_hold;

	abm_in_if  din ();
	abm_out_if dout ();

	audio_burst_muter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.din    (din),
		.dout   (dout)
	);

	abm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.din        (din),
		.dout       (dout),
		.errors     (errors),
		.pending    (pending),
		.results    (results),
		.bursts_seen(bursts_seen)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	initial begin
		#1ms;
		$display("simulation failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold on request
	initial begin
		dout.ready = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				dout.ready <= 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 0;
			end else begin
				dout.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send(input logic mode, input logic signed [SB-1:0] smp);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			din.valid <= 0;
			@(negedge clk);
		end
		din.valid     <= 1;
		din.mode      <= mode;
		din.sample_in <= smp;
		do @(posedge clk); while (!din.ready);
		items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		din.valid <= 0;
		wait (pending == 0);
		repeat (200) @(negedge clk);
	endtask

	task automatic reg_write(input abm_pkg::reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1;
		pwrite  <= 1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
	endtask

	// Idle patterns: none, sender idle, receiver stalling, both
	task automatic set_phase(input int ph);
		case (ph)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 79;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 79;
			end
			default: begin
				idle_pct  = 34;
				stall_pct = 34;
			end
		endcase
	endtask

	// Four full blocks plus a short tail; the second block is loud and gets muted
	task automatic main_stream();
		int v;
		for (int i = 0; i < MAIN_PUSHES; i++) begin
			set_phase(i * 4 / MAIN_PUSHES);
			if (i >= BL && i < 2 * BL)
				v = int'($urandom());
			else
				v = int'($urandom_range(6000)) - 3000;
			send(1'b0, SB'(v));
		end
		for (int k = 0; k < MAIN_DRAINS; k++) begin
			set_phase(k * 4 / MAIN_DRAINS);
			if (k == 30)
				long_hold = 1;
			if (k == MAIN_DRAINS / 2)
				send(1'b0, SB'($urandom()));
			send(1'b1, SB'($urandom()));
		end
	endtask

	initial begin
		arst_n        = 0;
		psel          = 0;
		penable       = 0;
		pwrite        = 0;
		paddr         = '0;
		pwdata        = '0;
		din.valid     = 0;
		din.mode      = 0;
		din.sample_in = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		items_sent    = 0;
		long_hold     = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;

		// Directed: empty drain, extremes in a short stream, ignored push, drain past end
		send(1'b1, '0);
		send(1'b0, 24'sh7FFFFF);
		send(1'b0, -24'sh800000);
		send(1'b0, '0);
		send(1'b0, -24'sd1);
		send(1'b0, 24'sd1);
		send(1'b1, '0);
		send(1'b1, '0);
		send(1'b0, 24'sd1234);
		for (int k = 0; k < 3; k++)
			send(1'b1, '0);
		send(1'b1, '0);
		settle();

		reg_write(abm_pkg::REG_MIN_LEVEL, 32'd1000);
		reg_write(abm_pkg::REG_BURST_RATIO, 32'd3);
		main_stream();
		settle();

		$display("items sent %0d, samples checked %0d, muted samples %0d",
			items_sent, results, bursts_seen);
		$display("a short pass-through stream, then a four-block stream with one loud block");
		$display("drained under four idle patterns and one long receiver hold");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
